// ----- hdl/sdlb_pkg.sv -----
// Shared constants and a helper function for the swap distance lower bound unit.
package sdlb_pkg;

    localparam int CUBE_DIM_DEF = 4;
    localparam int LABEL_BITS   = 4;
    localparam int PLACE_W      = 64;
    localparam int BOUND_W      = 6;
    localparam int SUM_W        = 7;
    localparam int PEAK_W       = 3;
    localparam int CYC_W        = 4;

    function automatic logic [PEAK_W-1:0] pop_label(input logic [LABEL_BITS-1:0] x);
        logic [PEAK_W-1:0] c;
        c = '0;
        for (int b = 0; b < LABEL_BITS; b++) begin
            c = c + PEAK_W'(x[b]);
        end
        return c;
    endfunction

endpackage

// ----- hdl/swap_distance_lower_bound_unit.sv -----
// Top level: token swapping lower bound on a hypercube, one placement per clock.
//
//  channel   | handshake        | payload
//  ----------+------------------+----------------------------------------------
//  request   | start / busy     | i_op, i_placement
//  result    | o_done strobe    | o_bound, o_distance_sum, o_distance_peak,
//            |                  | o_cycle_bound, o_inversion_parity
//
// One request per cycle; busy is never raised. Each request is held in the
// request register, then passes through the reachability closure (CUBE_DIM
// squarings of the pointer graph) into the result register. Reset
// (synchronous, active low) clears both valid flags. The receiver cannot
// stall: each result is shown for exactly one cycle.
module swap_distance_lower_bound_unit #(
    parameter int CUBE_DIM = sdlb_pkg::CUBE_DIM_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_op,
    input  logic [sdlb_pkg::PLACE_W-1:0]      i_placement,
    output logic                              o_done,
    output logic [sdlb_pkg::BOUND_W-1:0]      o_bound,
    output logic [sdlb_pkg::SUM_W-1:0]        o_distance_sum,
    output logic [sdlb_pkg::PEAK_W-1:0]       o_distance_peak,
    output logic [sdlb_pkg::CYC_W-1:0]        o_cycle_bound,
    output logic                              o_inversion_parity
);
    import sdlb_pkg::*;

    localparam int NODES = 1 << CUBE_DIM;
    localparam int CNT_W = CUBE_DIM + 1;

    logic                  r_vld;
    logic                  r_op;
    logic [PLACE_W-1:0]    r_placement;

    logic                  r_done;
    logic [BOUND_W-1:0]    r_bound;
    logic [SUM_W-1:0]      r_sum;
    logic [PEAK_W-1:0]     r_peak;
    logic [CYC_W-1:0]      r_cyc;
    logic                  r_par;

    logic [BOUND_W-1:0]    n_bound;
    logic [SUM_W-1:0]      n_sum;
    logic [PEAK_W-1:0]     n_peak;
    logic [CYC_W-1:0]      n_cyc;
    logic                  n_par;

    logic [LABEL_BITS-1:0] lab [NODES];
    logic [NODES-1:0]      reach [CUBE_DIM+1][NODES];
    logic [CNT_W-1:0]      cycles;
    logic [SUM_W:0]        sum_inc;
    logic [BOUND_W-1:0]    half;
    logic [BOUND_W-1:0]    m_max;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= start && !busy;
        end
        if (start && !busy) begin
            r_op        <= i_op;
            r_placement <= i_placement;
        end
    end

    always_comb begin
        for (int i = 0; i < NODES; i++) begin
            lab[i] = r_placement[LABEL_BITS*i +: LABEL_BITS];
        end
    end

    always_comb begin
        logic [PEAK_W-1:0] d;
        n_sum  = '0;
        n_peak = '0;
        for (int i = 0; i < NODES; i++) begin
            d = pop_label(LABEL_BITS'(i) ^ lab[i]);
            n_sum = n_sum + SUM_W'(d);
            if (d > n_peak) begin
                n_peak = d;
            end
        end
    end

    // reachability in zero or one step, then square to cover every walk
    always_comb begin
        for (int j = 0; j < NODES; j++) begin
            reach[0][j] = '0;
            reach[0][j][j] = 1'b1;
            reach[0][j][lab[j][CUBE_DIM-1:0]] = 1'b1;
        end
        for (int s = 0; s < CUBE_DIM; s++) begin
            for (int j = 0; j < NODES; j++) begin
                reach[s+1][j] = '0;
                for (int k = 0; k < NODES; k++) begin
                    if (reach[s][j][k]) begin
                        reach[s+1][j] = reach[s+1][j] | reach[s][k];
                    end
                end
            end
        end
    end

    // a node opens a cycle when no lower node reaches it
    always_comb begin
        logic hit;
        cycles = '0;
        for (int i = 0; i < NODES; i++) begin
            hit = 1'b0;
            for (int j = 0; j < i; j++) begin
                hit = hit | reach[CUBE_DIM][j][i];
            end
            if (!hit) begin
                cycles = cycles + CNT_W'(1);
            end
        end
        n_cyc = CYC_W'(CNT_W'(NODES) - cycles);
    end

    always_comb begin
        n_par = 1'b0;
        for (int i = 0; i < NODES; i++) begin
            for (int j = i + 1; j < NODES; j++) begin
                n_par = n_par ^ (lab[i] > lab[j]);
            end
        end
    end

    always_comb begin
        sum_inc = {1'b0, n_sum} + (SUM_W+1)'(1);
        half    = sum_inc[BOUND_W:1];
        m_max   = half;
        if (BOUND_W'(n_peak) > m_max) begin
            m_max = BOUND_W'(n_peak);
        end
        if (BOUND_W'(n_cyc) > m_max) begin
            m_max = BOUND_W'(n_cyc);
        end
        if (r_op) begin
            n_bound = m_max + BOUND_W'(m_max[0] != n_par);
        end else begin
            n_bound = half;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld;
        end
        if (r_vld) begin
            r_bound <= n_bound;
            r_sum   <= n_sum;
            r_peak  <= n_peak;
            r_cyc   <= n_cyc;
            r_par   <= n_par;
        end
    end

    assign o_done             = r_done;
    assign o_bound            = r_bound;
    assign o_distance_sum     = r_sum;
    assign o_distance_peak    = r_peak;
    assign o_cycle_bound      = r_cyc;
    assign o_inversion_parity = r_par;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> ##1 o_done)
        else $error("result strobe missing two cycles after request");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result strobe right after reset");

    a_peak_in_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_distance_peak <= PEAK_W'(LABEL_BITS)
                    && SUM_W'(o_distance_peak) <= o_distance_sum))
        else $error("distance peak inconsistent with distance sum");

    a_bound_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((SUM_W+1)'(o_bound)
                    >= (({1'b0, o_distance_sum} + (SUM_W+1)'(1)) >> 1)))
        else $error("bound below half distance sum");

    a_cycle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ((CNT_W+1)'(o_cycle_bound) < (CNT_W+1)'(NODES)))
        else $error("cycle bound out of range");

endmodule

// ----- sim/tb.sv -----
// Self-checking testbench for the swap distance lower bound unit.
`timescale 1ns / 100ps

module tb;
    import sdlb_pkg::*;

    localparam int CUBE_DIM       = CUBE_DIM_DEF;
    localparam int NODES          = 1 << CUBE_DIM;
    localparam int RANDOM_ITEMS   = 1630;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [BOUND_W-1:0] bound;
        logic [SUM_W-1:0]   dsum;
        logic [PEAK_W-1:0]  peak;
        logic [CYC_W-1:0]   cyc;
        logic               par;
    } t_bound_res;

    typedef struct {
        logic               op;
        logic [PLACE_W-1:0] placement;
        bit                 typed;
        t_bound_res         res;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               i_op = 1'b0;
    logic [PLACE_W-1:0] i_placement = '0;
    logic               busy;
    logic               o_done;
    logic [BOUND_W-1:0] o_bound;
    logic [SUM_W-1:0]   o_distance_sum;
    logic [PEAK_W-1:0]  o_distance_peak;
    logic [CYC_W-1:0]   o_cycle_bound;
    logic               o_inversion_parity;

    t_bound_res bound_q [$];
    t_stim_row  directed_rows [$];
    int         n_fail = 0;
    int         n_checked = 0;
    int         n_req = 0;
    int         n_strong = 0;
    int         n_perm = 0;
    int         n_near = 0;
    int         n_raw = 0;
    int         idle_cycles = 0;

    swap_distance_lower_bound_unit #(
        .CUBE_DIM(CUBE_DIM)
    ) i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_op               (i_op),
        .i_placement        (i_placement),
        .o_done             (o_done),
        .o_bound            (o_bound),
        .o_distance_sum     (o_distance_sum),
        .o_distance_peak    (o_distance_peak),
        .o_cycle_bound      (o_cycle_bound),
        .o_inversion_parity (o_inversion_parity)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_bound_res predict_bound(logic op, logic [PLACE_W-1:0] p);
        logic [LABEL_BITS-1:0] lab [NODES];
        bit                    seen [NODES];
        int                    sum, peak, cycles, par, half, m, d, cur;
        t_bound_res            r;
        sum = 0;
        peak = 0;
        cycles = 0;
        par = 0;
        for (int i = 0; i < NODES; i++) begin
            lab[i] = p[LABEL_BITS*i +: LABEL_BITS];
            seen[i] = 1'b0;
        end
        for (int i = 0; i < NODES; i++) begin
            d = $countones(LABEL_BITS'(i) ^ lab[i]);
            sum += d;
            if (d > peak) peak = d;
        end
        for (int i = 0; i < NODES; i++) begin
            if (!seen[i]) begin
                cycles++;
                cur = i;
                for (int k = 0; k < NODES && !seen[cur]; k++) begin
                    seen[cur] = 1'b1;
                    cur = int'(lab[cur]) & (NODES - 1);
                end
            end
        end
        for (int i = 0; i < NODES; i++) begin
            for (int j = i + 1; j < NODES; j++) begin
                if (lab[i] > lab[j]) par ^= 1;
            end
        end
        half = (sum + 1) / 2;
        if (op == 1'b0) begin
            m = half;
        end else begin
            m = half;
            if (peak > m) m = peak;
            if ((NODES - cycles) > m) m = NODES - cycles;
            if ((m & 1) != par) m++;
        end
        r.bound = BOUND_W'(m);
        r.dsum  = SUM_W'(sum);
        r.peak  = PEAK_W'(peak);
        r.cyc   = CYC_W'(NODES - cycles);
        r.par   = par[0];
        return r;
    endfunction

    function automatic void add_row(logic op, logic [PLACE_W-1:0] p, bit typed,
                                    t_bound_res res);
        t_stim_row row;
        row.op        = op;
        row.placement = p;
        row.typed     = typed;
        row.res       = res;
        directed_rows = {directed_rows, row};
    endfunction

    function automatic int idle_gap(bit burst);
        int roll;
        roll = $urandom_range(0, 99);
        if (burst || roll < 60) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    task automatic issue_request(logic op, logic [PLACE_W-1:0] p, bit typed,
                                 t_bound_res typed_res, int gap, bit drain);
        t_bound_res want;
        start       <= 1'b1;
        i_op        <= op;
        i_placement <= p;
        do @(posedge i_clk); while (busy);
        want = typed ? typed_res : predict_bound(op, p);
        bound_q = {bound_q, want};
        n_req++;
        if (op) n_strong++;
        if (gap > 0 || drain) start <= 1'b0;
        repeat (gap) @(posedge i_clk);
        if (drain) begin
            while (bound_q.size() != 0) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        if ((start && !busy) || o_done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    always @(posedge i_clk) begin : result_check
        t_bound_res want;
        if (i_rst_n && o_done) begin
            if (bound_q.size() == 0) begin
                $error("result with no request pending: bound %0d", o_bound);
                n_fail++;
            end else begin
                want = bound_q.pop_front();
                n_checked++;
                if (o_bound !== want.bound) begin
                    $error("bound: expected %0d, got %0d", want.bound, o_bound);
                    n_fail++;
                end
                if (o_distance_sum !== want.dsum) begin
                    $error("distance_sum: expected %0d, got %0d", want.dsum, o_distance_sum);
                    n_fail++;
                end
                if (o_distance_peak !== want.peak) begin
                    $error("distance_peak: expected %0d, got %0d", want.peak, o_distance_peak);
                    n_fail++;
                end
                if (o_cycle_bound !== want.cyc) begin
                    $error("cycle_bound: expected %0d, got %0d", want.cyc, o_cycle_bound);
                    n_fail++;
                end
                if (o_inversion_parity !== want.par) begin
                    $error("inversion_parity: expected %0d, got %0d",
                           want.par, o_inversion_parity);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [LABEL_BITS-1:0] perm [NODES];
        logic [LABEL_BITS-1:0] t;
        logic [PLACE_W-1:0]    p;
        int                    kind, j, a, b, nswap;
        bit                    burst;

        add_row(1'b0, 64'hFEDCBA9876543210, 1'b1, '{6'd0, 7'd0, 3'd0, 4'd0, 1'b0});
        add_row(1'b1, 64'hFEDCBA9876543210, 1'b1, '{6'd0, 7'd0, 3'd0, 4'd0, 1'b0});
        add_row(1'b0, 64'h0000000000000000, 1'b1, '{6'd16, 7'd32, 3'd4, 4'd0, 1'b0});
        add_row(1'b1, 64'h0000000000000000, 1'b1, '{6'd16, 7'd32, 3'd4, 4'd0, 1'b0});
        add_row(1'b0, 64'hFFFFFFFFFFFFFFFF, 1'b1, '{6'd16, 7'd32, 3'd4, 4'd1, 1'b0});
        add_row(1'b1, 64'hFFFFFFFFFFFFFFFF, 1'b1, '{6'd16, 7'd32, 3'd4, 4'd1, 1'b0});
        add_row(1'b0, 64'h0123456789ABCDEF, 1'b1, '{6'd32, 7'd64, 3'd4, 4'd8, 1'b0});
        add_row(1'b1, 64'h0123456789ABCDEF, 1'b1, '{6'd32, 7'd64, 3'd4, 4'd8, 1'b0});
        add_row(1'b1, 64'hFEDCBA9876543201, 1'b0, '0);
        add_row(1'b0, 64'hFEDCBA9876540213, 1'b0, '0);
        add_row(1'b1, 64'hFEDCBA9876540213, 1'b0, '0);
        add_row(1'b1, 64'h0EDCBA987654321F, 1'b0, '0);
        add_row(1'b0, 64'h0FEDCBA987654321, 1'b0, '0);
        add_row(1'b1, 64'h0FEDCBA987654321, 1'b0, '0);
        add_row(1'b1, 64'h1111111111111111, 1'b0, '0);
        add_row(1'b0, 64'hA5A5A5A5A5A5A5A5, 1'b0, '0);
        add_row(1'b1, 64'h5A5A5A5A5A5A5A5A, 1'b0, '0);
        add_row(1'b1, 64'h8000000000000001, 1'b0, '0);
        add_row(1'b0, 64'h7FFFFFFFFFFFFFFE, 1'b0, '0);
        add_row(1'b1, 64'h0123456789ABCDEE, 1'b0, '0);
        add_row(1'b0, 64'h0123456789ABCDEE, 1'b0, '0);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            issue_request(directed_rows[r].op, directed_rows[r].placement,
                          directed_rows[r].typed, directed_rows[r].res,
                          idle_gap(1'b0), r == directed_rows.size() - 1);
        end

        burst = 1'b0;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 64 == 0) burst = ($urandom_range(0, 3) == 0);
            p = {$urandom, $urandom};
            kind = $urandom_range(0, 99);
            if (kind < 75) begin
                for (int i = 0; i < NODES; i++) perm[i] = LABEL_BITS'(i);
                if (kind < 55) begin
                    for (int i = NODES - 1; i > 0; i--) begin
                        j = $urandom_range(0, i);
                        t = perm[i];
                        perm[i] = perm[j];
                        perm[j] = t;
                    end
                    n_perm++;
                end else begin
                    nswap = $urandom_range(1, 3);
                    for (int s = 0; s < nswap; s++) begin
                        a = $urandom_range(0, NODES - 1);
                        b = $urandom_range(0, NODES - 1);
                        t = perm[a];
                        perm[a] = perm[b];
                        perm[b] = t;
                    end
                    n_near++;
                end
                for (int i = 0; i < NODES; i++) p[LABEL_BITS*i +: LABEL_BITS] = perm[i];
            end else begin
                n_raw++;
            end
            issue_request(1'($urandom_range(0, 1)), p, 1'b0, '0, idle_gap(burst),
                          n == RANDOM_ITEMS / 2);
        end

        start <= 1'b0;
        while (bound_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Sent %0d placements (%0d strong, %0d basic), compared %0d results.",
                 n_req, n_strong, n_req - n_strong, n_checked);
        $display("Random mix: %0d shuffles, %0d near-sorted, %0d raw words.",
                 n_perm, n_near, n_raw);
        if (n_fail == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
